// File: src/source_token_lexer_defines.svh
// Assertion macros shared by the lexer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SOURCE_TOKEN_LEXER_DEFINES_SVH
`define SOURCE_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define STL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, disabled while reset is held.
`define STL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// File: src/stl_pkg.sv
// Shared constants, types and character helpers of the source token lexer.
// Depends on nothing; used by the lexer modules and the bench.
package stl_pkg;

    localparam int POS_BITS = 16;
    localparam int KW_MAX   = 6;
    localparam int WIN_BITS = 8 * KW_MAX;
    localparam int WORD_CNT = 8;
    localparam int KW_CNT   = 6;

    localparam logic [POS_BITS-1:0] POS_MAX   = '1;
    localparam logic [7:0]          SPACE_MAX = 8'hFF;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_IDX   = $clog2(RQ_DEPTH);
    localparam int RQ_CNT   = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NCODE = 8'h6E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [2:0] OP_PLUS  = 3'd0;
    localparam logic [2:0] OP_MINUS = 3'd1;
    localparam logic [2:0] OP_STAR  = 3'd2;
    localparam logic [2:0] OP_SLASH = 3'd3;
    localparam logic [2:0] OP_EQ    = 3'd4;
    localparam logic [2:0] OP_BANG  = 3'd5;
    localparam logic [7:0] OP_PAIR_OFS = 8'd5;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_OP      = 3'd3,
        MODE_COMMENT = 3'd4
    } t_lex_mode;

    typedef enum logic [2:0] {
        KIND_ID    = 3'd0,
        KIND_KW    = 3'd1,
        KIND_BOOL  = 3'd2,
        KIND_INT   = 3'd3,
        KIND_OP    = 3'd4,
        KIND_PUNCT = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  spaces;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    // def return if and or else False True, first character in the top used byte
    localparam logic [63:0] WORD_TAB [WORD_CNT] = '{
        64'h646566, 64'h72657475726E, 64'h6966, 64'h616E64,
        64'h6F72, 64'h656C7365, 64'h46616C7365, 64'h54727565
    };
    localparam logic [3:0] WORD_LEN [WORD_CNT] = '{
        4'd3, 4'd6, 4'd2, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4
    };

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH
            || c == CH_EQ || c == CH_BANG;
    endfunction

    function automatic logic [2:0] op_index(logic [7:0] c);
        logic [2:0] idx;
        unique case (c)
            CH_PLUS:  idx = OP_PLUS;
            CH_MINUS: idx = OP_MINUS;
            CH_STAR:  idx = OP_STAR;
            CH_SLASH: idx = OP_SLASH;
            CH_EQ:    idx = OP_EQ;
            CH_BANG:  idx = OP_BANG;
            default:  idx = OP_PLUS;
        endcase
        return idx;
    endfunction

endpackage

// File: src/stl_ifs.sv
// Valid/ready channel interfaces of the lexer: character beats in, token beats out.
// Depends on nothing.
interface stl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface stl_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  token_code;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  leading_spaces;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_code, output token_start,
                    output token_length, output leading_spaces, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_code, input token_start,
                    input token_length, input leading_spaces, input last_of_run,
                    output ready);
endinterface

// File: src/source_token_lexer.sv
// Source token lexer top level: lexer step followed by the token result queue.
// Depends on stl_pkg, stl_ifs, stl_core and stl_res_q.
//
//   channel    dir  modport  beat
//   i_char_if  in   sink     one source byte plus end-of-input flag
//   o_tok_if   out  source   one token descriptor
//
// A byte enters the input register, is lexed from it once the queue has room and its tokens
// land in a four-entry queue; one byte per cycle is taken while the queue has room for two.
// A byte yields zero to two tokens; the output drains one per cycle, so bytes that
// yield two tokens take two output beats when the sink is always ready.
// Reset is synchronous, active low, and returns the lexer to idle at position zero.
// Output stalls back up through the queue to i_char_if.ready.
module source_token_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stl_char_if.sink    i_char_if,
    stl_tok_if.source   o_tok_if
);

    stl_pkg::t_push push;
    logic           room;

    stl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char_if),
        .i_room  (room),
        .o_push  (push)
    );

    stl_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok_if)
    );

endmodule

// File: src/stl_core.sv
// Lexer step: input beat register, mode/token state and the per-character decode.
// Depends on stl_pkg, stl_ifs and source_token_lexer_defines.svh.
`include "source_token_lexer_defines.svh"

module stl_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    stl_char_if.sink             i_char,
    input  logic                 i_room,
    output stl_pkg::t_push       o_push
);

    logic                           r_in_vld, n_in_vld;
    logic [7:0]                     r_char;
    logic                           r_eoi;
    stl_pkg::t_lex_mode             r_mode, n_mode, n_mid_mode;
    logic [7:0]                     r_pend, m_pend;
    logic [stl_pkg::WIN_BITS-1:0]   r_win, m_win;
    logic [stl_pkg::POS_BITS-1:0]   r_start, m_start;
    logic [stl_pkg::POS_BITS-1:0]   r_len, m_len;
    logic [7:0]                     r_spc, m_spc;
    logic [7:0]                     r_rs, m_rs, n_rs;
    logic [stl_pkg::POS_BITS-1:0]   r_pos, n_pos;

    logic fire, in_acc;
    logic letter, digit, opc, space, hash, nl;
    logic cont, opeq, proc_idle, is_punct;
    logic e1v, e2v, e3v;
    stl_pkg::t_token e1, e2, e3;

    function automatic logic has_token(stl_pkg::t_lex_mode m);
        return m == stl_pkg::MODE_IDENT || m == stl_pkg::MODE_NUMBER
            || m == stl_pkg::MODE_OP;
    endfunction

    function automatic stl_pkg::t_token finish_tok(
        stl_pkg::t_lex_mode             m,
        logic [stl_pkg::POS_BITS-1:0]   st,
        logic [stl_pkg::POS_BITS-1:0]   len,
        logic [7:0]                     sp,
        logic [stl_pkg::WIN_BITS-1:0]   win,
        logic [7:0]                     pend
    );
        stl_pkg::t_token t;
        logic            hit;
        t.kind   = stl_pkg::KIND_ID;
        t.code   = 8'd0;
        t.start  = 16'(st);
        t.length = 16'(len);
        t.spaces = sp;
        t.last   = 1'b0;
        hit      = 1'b0;
        unique case (m)
            stl_pkg::MODE_IDENT: begin
                if (len <= stl_pkg::POS_BITS'(stl_pkg::KW_MAX)) begin
                    for (int i = 0; i < stl_pkg::WORD_CNT; i++) begin
                        if (!hit && len == stl_pkg::POS_BITS'(stl_pkg::WORD_LEN[i])
                            && win == stl_pkg::WIN_BITS'(stl_pkg::WORD_TAB[i])) begin
                            hit = 1'b1;
                            if (i < stl_pkg::KW_CNT) begin
                                t.kind = stl_pkg::KIND_KW;
                                t.code = 8'(i);
                            end else begin
                                t.kind = stl_pkg::KIND_BOOL;
                                t.code = 8'(i - stl_pkg::KW_CNT);
                            end
                        end
                    end
                end
            end
            stl_pkg::MODE_NUMBER: begin
                t.kind = stl_pkg::KIND_INT;
            end
            stl_pkg::MODE_OP: begin
                t.length = 16'd1;
                if (pend == stl_pkg::CH_BANG) begin
                    t.kind = stl_pkg::KIND_PUNCT;
                    t.code = stl_pkg::CH_BANG;
                end else begin
                    t.kind = stl_pkg::KIND_OP;
                    t.code = 8'(stl_pkg::op_index(pend));
                end
            end
            default: begin
                t.kind = stl_pkg::KIND_ID;
            end
        endcase
        return t;
    endfunction

    assign fire         = r_in_vld && i_room;
    assign i_char.ready = !r_in_vld || fire;
    assign in_acc       = i_char.valid && i_char.ready;
    assign n_in_vld     = in_acc || (r_in_vld && !fire);

    // character decode
    always_comb begin
        letter    = stl_pkg::is_letter(r_char);
        digit     = stl_pkg::is_digit(r_char);
        opc       = stl_pkg::is_op(r_char);
        space     = r_char == stl_pkg::CH_SPACE;
        hash      = r_char == stl_pkg::CH_HASH;
        nl        = r_char == stl_pkg::CH_NL;
        cont      = (r_mode == stl_pkg::MODE_IDENT && (letter || digit))
                 || (r_mode == stl_pkg::MODE_NUMBER && digit);
        opeq      = r_mode == stl_pkg::MODE_OP && r_char == stl_pkg::CH_EQ;
        proc_idle = !cont && !opeq && r_mode != stl_pkg::MODE_COMMENT;
        is_punct  = proc_idle && !space && !hash && !letter && !digit && !opc;
    end

    // next mode
    always_comb begin
        n_mid_mode = r_mode;
        priority if (cont) begin
            n_mid_mode = r_mode;
        end else if (opeq) begin
            n_mid_mode = stl_pkg::MODE_IDLE;
        end else if (r_mode == stl_pkg::MODE_COMMENT) begin
            n_mid_mode = nl ? stl_pkg::MODE_IDLE : stl_pkg::MODE_COMMENT;
        end else if (hash) begin
            n_mid_mode = stl_pkg::MODE_COMMENT;
        end else if (letter) begin
            n_mid_mode = stl_pkg::MODE_IDENT;
        end else if (digit) begin
            n_mid_mode = stl_pkg::MODE_NUMBER;
        end else if (opc) begin
            n_mid_mode = stl_pkg::MODE_OP;
        end else begin
            n_mid_mode = stl_pkg::MODE_IDLE;
        end
        n_mode = r_eoi ? stl_pkg::MODE_IDLE : n_mid_mode;
    end

    // token bookkeeping
    always_comb begin
        m_start = r_start;
        m_len   = r_len;
        m_spc   = r_spc;
        m_win   = r_win;
        m_pend  = r_pend;
        m_rs    = r_rs;
        if (cont) begin
            if (r_len != stl_pkg::POS_MAX) begin
                m_len = r_len + 1'b1;
            end
            if (r_mode == stl_pkg::MODE_IDENT) begin
                m_win = {r_win[stl_pkg::WIN_BITS-9:0], r_char};
            end
        end else if (proc_idle) begin
            if (space) begin
                if (r_rs != stl_pkg::SPACE_MAX) begin
                    m_rs = r_rs + 1'b1;
                end
            end else if (letter || digit || opc) begin
                m_start = r_pos;
                m_len   = stl_pkg::POS_BITS'(1);
                m_spc   = r_rs;
                m_rs    = 8'd0;
                if (letter) begin
                    m_win = stl_pkg::WIN_BITS'(r_char);
                end
                if (opc) begin
                    m_pend = r_char;
                end
            end else begin
                m_rs = 8'd0;
            end
        end
        n_rs  = r_eoi ? 8'd0 : m_rs;
        n_pos = r_eoi ? '0 : ((r_pos == stl_pkg::POS_MAX) ? r_pos : r_pos + 1'b1);
    end

    // result beats of this character
    always_comb begin
        e1v = 1'b0;
        e1  = finish_tok(r_mode, r_start, r_len, r_spc, r_win, r_pend);
        if (opeq) begin
            e1v     = 1'b1;
            e1.kind = stl_pkg::KIND_OP;
            e1.code = 8'(stl_pkg::op_index(r_pend)) + stl_pkg::OP_PAIR_OFS;
            e1.length = 16'd2;
        end else if (proc_idle && has_token(r_mode)) begin
            e1v = 1'b1;
        end

        e2v       = is_punct;
        e2.kind   = stl_pkg::KIND_PUNCT;
        e2.code   = nl ? stl_pkg::CH_NCODE : r_char;
        e2.start  = 16'(r_pos);
        e2.length = 16'd1;
        e2.spaces = r_rs;
        e2.last   = 1'b0;

        e3v = r_eoi && has_token(n_mid_mode);
        e3  = finish_tok(n_mid_mode, m_start, m_len, m_spc, m_win, m_pend);

        o_push.tok0 = e1v ? e1 : (e2v ? e2 : e3);
        o_push.tok1 = (e1v && e2v) ? e2 : e3;
        o_push.cnt  = 2'(e1v) + 2'(e2v) + 2'(e3v);
        if (!fire) begin
            o_push.cnt = 2'd0;
        end
        o_push.tok0.last = o_push.cnt == 2'd1;
        o_push.tok1.last = o_push.cnt == 2'd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= stl_pkg::MODE_IDLE;
            r_pend   <= 8'd0;
            r_win    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_spc    <= 8'd0;
            r_rs     <= 8'd0;
            r_pos    <= '0;
        end else begin
            r_in_vld <= n_in_vld;
            if (fire) begin
                r_mode  <= n_mode;
                r_pend  <= m_pend;
                r_win   <= m_win;
                r_start <= m_start;
                r_len   <= m_len;
                r_spc   <= m_spc;
                r_rs    <= n_rs;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char <= i_char.char_in;
            r_eoi  <= i_char.end_of_input;
        end
    end

    `STL_ASSERT_NXT(a_eoi_restart, i_clk, i_rst_n, fire && r_eoi, r_mode == stl_pkg::MODE_IDLE && r_pos == '0 && r_rs == 8'd0)
    `STL_ASSERT_IMP(a_comment_silent, i_clk, i_rst_n, r_mode == stl_pkg::MODE_COMMENT, o_push.cnt == 2'd0)
    `STL_ASSERT_IMP(a_pair_order, i_clk, i_rst_n, o_push.cnt == 2'd2, !o_push.tok0.last && o_push.tok1.last)
    `STL_ASSERT_IMP(a_push_bounded, i_clk, i_rst_n, o_push.cnt != 2'd0, i_room && o_push.cnt != 2'd3)

endmodule

// File: src/stl_res_q.sv
// Result queue: takes up to two token beats per cycle, hands out one per cycle while the sink is ready.
// Depends on stl_pkg, stl_ifs and source_token_lexer_defines.svh.
`include "source_token_lexer_defines.svh"

module stl_res_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stl_pkg::t_push     i_push,
    output logic               o_room,
    stl_tok_if.source          o_tok
);

    stl_pkg::t_token             r_mem [stl_pkg::RQ_DEPTH];
    logic [stl_pkg::RQ_IDX-1:0]  r_wr, n_wr;
    logic [stl_pkg::RQ_IDX-1:0]  r_rd, n_rd;
    logic [stl_pkg::RQ_CNT-1:0]  r_cnt, n_cnt;
    logic                        pop;
    logic [stl_pkg::RQ_IDX-1:0]  wr_nxt;
    stl_pkg::t_token             head;

    assign pop    = o_tok.valid && o_tok.ready;
    assign o_room = r_cnt <= stl_pkg::RQ_CNT'(stl_pkg::RQ_DEPTH - 2);
    assign wr_nxt = r_wr + 1'b1;
    assign n_wr   = r_wr + stl_pkg::RQ_IDX'(i_push.cnt);
    assign n_rd   = r_rd + stl_pkg::RQ_IDX'(pop);
    assign n_cnt  = r_cnt + stl_pkg::RQ_CNT'(i_push.cnt) - stl_pkg::RQ_CNT'(pop);
    assign head   = r_mem[r_rd];

    assign o_tok.valid          = r_cnt != '0;
    assign o_tok.token_kind     = head.kind;
    assign o_tok.token_code     = head.code;
    assign o_tok.token_start    = head.start;
    assign o_tok.token_length   = head.length;
    assign o_tok.leading_spaces = head.spaces;
    assign o_tok.last_of_run    = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_nxt] <= i_push.tok1;
        end
    end

    `STL_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= stl_pkg::RQ_CNT'(stl_pkg::RQ_DEPTH))
    `STL_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.cnt != 2'd0, o_room)
    `STL_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, r_cnt == '0, r_wr == r_rd)

endmodule

// File: verif/tb_source_token_lexer.sv
`timescale 1ns / 1ps
// Self-checking bench for source_token_lexer: character beats in, token descriptors out.
// Depends on stl_pkg, the stl_char_if/stl_tok_if interfaces and the lexer RTL.
module tb_source_token_lexer;

    localparam int MAX_WAIT    = 18;
    localparam int RAND_BEATS  = 350;
    localparam int LONG_IDENT  = 10;
    localparam int SAT_SPACES  = 260;
    localparam int TAIL_CYCLES = 16;
    localparam int DIR_ROWS    = 25;

    localparam logic [7:0] KW_DEF     = 8'd0;
    localparam logic [7:0] KW_RETURN  = 8'd1;
    localparam logic [7:0] KW_IF      = 8'd2;
    localparam logic [7:0] KW_AND     = 8'd3;
    localparam logic [7:0] KW_OR      = 8'd4;
    localparam logic [7:0] KW_ELSE    = 8'd5;
    localparam logic [7:0] BOOL_FALSE = 8'd0;
    localparam logic [7:0] BOOL_TRUE  = 8'd1;

    localparam logic [stl_pkg::WIN_BITS-1:0] W_DEF    = "def";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_RETURN = "return";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_IF     = "if";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_AND    = "and";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_OR     = "or";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_ELSE   = "else";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_TRUE   = "True";
    localparam logic [stl_pkg::WIN_BITS-1:0] W_FALSE  = "False";

    localparam stl_pkg::t_token NO_TOK = '0;

    typedef enum logic [1:0] {CC_LETTER, CC_DIGIT, CC_OP, CC_OTHER} t_cclass;
    typedef enum logic [1:0] {PACE_NONE, PACE_SHORT, PACE_FULL} t_pace;

    typedef struct {
        logic [7:0]      chr;
        logic            eoi;
        logic            typed;
        stl_pkg::t_token want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stl_char_if char_if ();
    stl_tok_if  tok_if ();

    source_token_lexer i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_if (char_if),
        .o_tok_if  (tok_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_pace pace = PACE_FULL;
    int    errors = 0;
    int    beats_in = 0;
    int    tokens_out = 0;

    // lexer shadow state
    stl_pkg::t_lex_mode           lx_mode  = stl_pkg::MODE_IDLE;
    logic [7:0]                   lx_op    = '0;
    logic [stl_pkg::WIN_BITS-1:0] lx_win   = '0;
    logic [15:0]                  lx_start = '0;
    logic [15:0]                  lx_len   = '0;
    logic [7:0]                   lx_sp    = '0;
    logic [7:0]                   lx_run   = '0;
    logic [15:0]                  lx_pos   = '0;

    stl_pkg::t_token step_toks[$];
    stl_pkg::t_token tok_expect[$];

    logic [7:0] stream_q[$];
    t_stim_row  dir_rows [DIR_ROWS];

    string kw_words [12] = '{"def", "return", "if", "and", "or", "else", "True", "False",
                             "returns", "Tru", "el", "iff"};
    string op_set    = "+-*/=!";
    string punct_set = "(),:[]{}.;'";

    function automatic t_cclass classify(logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CC_LETTER;
        if (c >= "0" && c <= "9") return CC_DIGIT;
        if (c == stl_pkg::CH_PLUS || c == stl_pkg::CH_MINUS || c == stl_pkg::CH_STAR ||
            c == stl_pkg::CH_SLASH || c == stl_pkg::CH_EQ || c == stl_pkg::CH_BANG)
            return CC_OP;
        return CC_OTHER;
    endfunction

    function automatic logic [2:0] op_code_of(logic [7:0] c);
        unique case (c)
            stl_pkg::CH_MINUS: return stl_pkg::OP_MINUS;
            stl_pkg::CH_STAR:  return stl_pkg::OP_STAR;
            stl_pkg::CH_SLASH: return stl_pkg::OP_SLASH;
            stl_pkg::CH_EQ:    return stl_pkg::OP_EQ;
            stl_pkg::CH_BANG:  return stl_pkg::OP_BANG;
            default:           return stl_pkg::OP_PLUS;
        endcase
    endfunction

    function automatic void push_tok(stl_pkg::t_kind k, logic [7:0] code, logic [15:0] start,
                                     logic [15:0] len, logic [7:0] sp);
        stl_pkg::t_token t;
        t.kind   = k;
        t.code   = code;
        t.start  = start;
        t.length = len;
        t.spaces = sp;
        t.last   = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void open_tok(stl_pkg::t_lex_mode m, logic [15:0] at);
        lx_mode  = m;
        lx_start = at;
        lx_len   = 16'd1;
        lx_sp    = lx_run;
        lx_run   = '0;
    endfunction

    function automatic void close_tok();
        stl_pkg::t_kind k;
        logic [7:0]     code;
        k = stl_pkg::KIND_ID;
        code = '0;
        unique case (lx_mode)
            stl_pkg::MODE_IDENT: begin
                if (lx_len <= stl_pkg::KW_MAX) begin
                    unique case (lx_win)
                        W_DEF:    begin k = stl_pkg::KIND_KW;   code = KW_DEF;     end
                        W_RETURN: begin k = stl_pkg::KIND_KW;   code = KW_RETURN;  end
                        W_IF:     begin k = stl_pkg::KIND_KW;   code = KW_IF;      end
                        W_AND:    begin k = stl_pkg::KIND_KW;   code = KW_AND;     end
                        W_OR:     begin k = stl_pkg::KIND_KW;   code = KW_OR;      end
                        W_ELSE:   begin k = stl_pkg::KIND_KW;   code = KW_ELSE;    end
                        W_TRUE:   begin k = stl_pkg::KIND_BOOL; code = BOOL_TRUE;  end
                        W_FALSE:  begin k = stl_pkg::KIND_BOOL; code = BOOL_FALSE; end
                        default: ;
                    endcase
                end
                push_tok(k, code, lx_start, lx_len, lx_sp);
            end
            stl_pkg::MODE_NUMBER: push_tok(stl_pkg::KIND_INT, '0, lx_start, lx_len, lx_sp);
            stl_pkg::MODE_OP: begin
                if (lx_op == stl_pkg::CH_BANG)
                    push_tok(stl_pkg::KIND_PUNCT, stl_pkg::CH_BANG, lx_start, 16'd1, lx_sp);
                else
                    push_tok(stl_pkg::KIND_OP, 8'(op_code_of(lx_op)), lx_start, 16'd1, lx_sp);
            end
            default: ;
        endcase
        if (lx_mode != stl_pkg::MODE_COMMENT) lx_mode = stl_pkg::MODE_IDLE;
    endfunction

    function automatic void idle_byte(logic [7:0] c, logic [15:0] at);
        if (c == stl_pkg::CH_SPACE) begin
            if (lx_run != stl_pkg::SPACE_MAX) lx_run = lx_run + 8'd1;
        end else if (c == stl_pkg::CH_HASH) begin
            lx_mode = stl_pkg::MODE_COMMENT;
            lx_run  = '0;
        end else begin
            unique case (classify(c))
                CC_LETTER: begin
                    open_tok(stl_pkg::MODE_IDENT, at);
                    lx_win = {{(stl_pkg::WIN_BITS-8){1'b0}}, c};
                end
                CC_DIGIT: open_tok(stl_pkg::MODE_NUMBER, at);
                CC_OP: begin
                    open_tok(stl_pkg::MODE_OP, at);
                    lx_op = c;
                end
                default: begin
                    push_tok(stl_pkg::KIND_PUNCT, (c == stl_pkg::CH_NL) ? stl_pkg::CH_NCODE : c,
                             at, 16'd1, lx_run);
                    lx_run = '0;
                end
            endcase
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic eoi);
        logic [15:0] at;
        t_cclass     cc;
        at = lx_pos;
        cc = classify(c);
        step_toks.delete();
        unique case (lx_mode)
            stl_pkg::MODE_IDENT: begin
                if (cc == CC_LETTER || cc == CC_DIGIT) begin
                    if (lx_len != stl_pkg::POS_MAX) lx_len = lx_len + 16'd1;
                    lx_win = {lx_win[stl_pkg::WIN_BITS-9:0], c};
                end else begin
                    close_tok();
                    idle_byte(c, at);
                end
            end
            stl_pkg::MODE_NUMBER: begin
                if (cc == CC_DIGIT) begin
                    if (lx_len != stl_pkg::POS_MAX) lx_len = lx_len + 16'd1;
                end else begin
                    close_tok();
                    idle_byte(c, at);
                end
            end
            stl_pkg::MODE_OP: begin
                if (c == stl_pkg::CH_EQ) begin
                    push_tok(stl_pkg::KIND_OP, 8'(op_code_of(lx_op)) + stl_pkg::OP_PAIR_OFS,
                             lx_start, 16'd2, lx_sp);
                    lx_mode = stl_pkg::MODE_IDLE;
                end else begin
                    close_tok();
                    idle_byte(c, at);
                end
            end
            stl_pkg::MODE_COMMENT: begin
                if (c == stl_pkg::CH_NL) lx_mode = stl_pkg::MODE_IDLE;
            end
            default: idle_byte(c, at);
        endcase
        if (lx_pos != stl_pkg::POS_MAX) lx_pos = lx_pos + 16'd1;
        if (eoi) begin
            close_tok();
            lx_mode = stl_pkg::MODE_IDLE;
            lx_pos  = '0;
            lx_run  = '0;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) tok_expect.push_back(step_toks[i]);
    endfunction

    function automatic int draw_wait();
        unique case (pace)
            PACE_NONE:  return 0;
            PACE_SHORT: return $urandom_range(0, 3);
            default:    return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    // append one lexical fragment to the stream being built
    function automatic void add_frag();
        int    sel;
        int    n;
        string w;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            if ($urandom_range(0, 1)) begin
                w = kw_words[$urandom_range(0, 11)];
                for (int i = 0; i < w.len(); i++) stream_q.push_back(w[i]);
            end else begin
                n = $urandom_range(1, 9);
                stream_q.push_back(rand_letter());
                for (int i = 1; i < n; i++)
                    stream_q.push_back($urandom_range(0, 2) ? rand_letter() : rand_digit());
            end
        end else if (sel < 37) begin
            n = $urandom_range(1, 5);
            repeat (n) stream_q.push_back(rand_digit());
        end else if (sel < 52) begin
            stream_q.push_back(op_set[$urandom_range(0, op_set.len() - 1)]);
            if ($urandom_range(0, 1)) stream_q.push_back(stl_pkg::CH_EQ);
        end else if (sel < 62) begin
            n = $urandom_range(0, 4) == 0 ? $urandom_range(5, 20) : $urandom_range(1, 4);
            repeat (n) stream_q.push_back(stl_pkg::CH_SPACE);
        end else if (sel < 68) begin
            stream_q.push_back(stl_pkg::CH_NL);
        end else if (sel < 75) begin
            stream_q.push_back(stl_pkg::CH_HASH);
            n = $urandom_range(0, 6);
            repeat (n) stream_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 4) != 0) stream_q.push_back(stl_pkg::CH_NL);
        end else if (sel < 85) begin
            stream_q.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
        end else begin
            stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(logic [7:0] c, logic eoi, logic typed, stl_pkg::t_token want);
        int gap;
        int keep;
        gap = draw_wait();
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        char_if.valid        <= 1'b1;
        char_if.char_in      <= c;
        char_if.end_of_input <= eoi;
        do @(posedge i_clk); while (!char_if.ready);
        keep = tok_expect.size();
        lex_byte(c, eoi);
        if (typed) begin
            while (tok_expect.size() > keep) void'(tok_expect.pop_back());
            tok_expect.push_back(want);
        end
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        char_if.valid <= 1'b0;
        while (tok_expect.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // token sink: random stall per beat, compare against the oldest expectation
    initial begin
        int              stall;
        stl_pkg::t_token want;
        tok_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            tok_if.ready <= 1'b1;
            do @(posedge i_clk); while (!tok_if.valid);
            tokens_out++;
            if (tok_expect.size() == 0) begin
                $error("token beat with nothing expected: kind %0d start %0d",
                       tok_if.token_kind, tok_if.token_start);
                errors++;
            end else begin
                want = tok_expect.pop_front();
                cmp_field("token_kind", 16'(want.kind), 16'(tok_if.token_kind));
                cmp_field("token_code", 16'(want.code), 16'(tok_if.token_code));
                cmp_field("token_start", want.start, tok_if.token_start);
                cmp_field("token_length", want.length, tok_if.token_length);
                cmp_field("leading_spaces", 16'(want.spaces), 16'(tok_if.leading_spaces));
                cmp_field("last_of_run", 16'(want.last), 16'(tok_if.last_of_run));
            end
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout: lexer stopped making progress");
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int target;
        i_rst_n              <= 1'b0;
        char_if.valid        <= 1'b0;
        char_if.char_in      <= '0;
        char_if.end_of_input <= 1'b0;

        dir_rows = '{
            '{8'h00, 1'b0, 1'b1,
              '{stl_pkg::KIND_PUNCT, 8'h00, 16'd0, 16'd1, 8'd0, 1'b1}},
            '{stl_pkg::CH_SPACE, 1'b0, 1'b0, NO_TOK},
            '{"d",               1'b0, 1'b0, NO_TOK},
            '{"e",               1'b0, 1'b0, NO_TOK},
            '{"f",               1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_NL,    1'b0, 1'b0, NO_TOK},
            '{"9",               1'b0, 1'b0, NO_TOK},
            '{"x",               1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_BANG,  1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_EQ,    1'b0, 1'b1,
              '{stl_pkg::KIND_OP, 8'(stl_pkg::OP_BANG) + stl_pkg::OP_PAIR_OFS,
                16'd8, 16'd2, 8'd0, 1'b1}},
            '{stl_pkg::CH_BANG,  1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_SPACE, 1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_HASH,  1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_NL,    1'b0, 1'b0, NO_TOK},
            '{"F",               1'b0, 1'b0, NO_TOK},
            '{"a",               1'b0, 1'b0, NO_TOK},
            '{"l",               1'b0, 1'b0, NO_TOK},
            '{"s",               1'b0, 1'b0, NO_TOK},
            '{"e",               1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_SLASH, 1'b0, 1'b0, NO_TOK},
            '{8'hFF,             1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_MINUS, 1'b0, 1'b0, NO_TOK},
            '{stl_pkg::CH_EQ,    1'b1, 1'b1,
              '{stl_pkg::KIND_OP, 8'(stl_pkg::OP_MINUS) + stl_pkg::OP_PAIR_OFS,
                16'd21, 16'd2, 8'd0, 1'b1}},
            '{stl_pkg::CH_STAR,  1'b1, 1'b1,
              '{stl_pkg::KIND_OP, 8'(stl_pkg::OP_STAR), 16'd0, 16'd1, 8'd0, 1'b1}},
            '{stl_pkg::CH_HASH,  1'b1, 1'b0, NO_TOK}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].chr, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].want);

        // random streams: mostly well-formed fragments, some noise bytes
        while (beats_in < DIR_ROWS + RAND_BEATS) begin
            pace = t_pace'($urandom_range(0, 2));
            stream_q.delete();
            target = $urandom_range(3, 40);
            while (stream_q.size() < target) add_frag();
            foreach (stream_q[i])
                send_beat(stream_q[i], (i == stream_q.size() - 1) || ($urandom_range(0, 49) == 0),
                          1'b0, NO_TOK);
        end
        wait_drain();

        // long identifier, then enough spaces to saturate the space count
        pace = PACE_NONE;
        send_beat(rand_letter(), 1'b0, 1'b0, NO_TOK);
        repeat (LONG_IDENT - 1)
            send_beat($urandom_range(0, 3) ? rand_letter() : rand_digit(), 1'b0, 1'b0, NO_TOK);
        repeat (SAT_SPACES) send_beat(stl_pkg::CH_SPACE, 1'b0, 1'b0, NO_TOK);
        send_beat("1", 1'b1, 1'b0, NO_TOK);
        wait_drain();

        $display("Lexed %0d character beats into %0d token beats: directed cases,", beats_in,
                 tokens_out);
        $display("random streams with noise, a long identifier and a saturating space run.");
        if (errors == 0 && tok_expect.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
